>>> rtl/core/adw_pkg.sv
// ----------------------------------------------------------------------------
// adw_pkg
// Shared types and constants of the AdaGrad weight update pipeline.
// ----------------------------------------------------------------------------
package adw_pkg;

  localparam int unsigned IDX_W      = 12;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned BATCH_W    = 16;
  localparam int unsigned DEN_W      = 48;
  localparam int unsigned QUOT_W     = 34;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned DIV_STAGES  = QUOT_W;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE    = 8'd1;

  localparam logic [DATA_W-1:0]  LR_RESET    = 32'h0001_0000;
  localparam logic [BATCH_W-1:0] BATCH_RESET = 16'd1;

  localparam logic [QUOT_W-1:0] STEP_MAX = 34'h2_0000_0000;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic              neg;
    logic [DATA_W-1:0] weight;
    logic [DATA_W-1:0] mag;
  } item_t;

endpackage

>>> rtl/core/adagrad_weight_update.sv
// ----------------------------------------------------------------------------
// adagrad_weight_update
// Pipeline: stage P, stage A, the square root, stage M, the divider, stage O.
// Throughput: one request per cycle when not stalled; the 32-stage square root
// and the 34-stage divider each retire one bit per stage under a common stall.
// Reset: after reset the accumulator memory is cleared one entry per cycle, all
// NUM_ELEMENTS entries, during which no request is accepted.
// ----------------------------------------------------------------------------
module adagrad_weight_update #(
  parameter int unsigned NUM_ELEMENTS = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [adw_pkg::IDX_W-1:0]         element_index_i,
  input  logic signed [adw_pkg::DATA_W-1:0] gradient_i,
  input  logic signed [adw_pkg::DATA_W-1:0] weight_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [adw_pkg::DATA_W-1:0] updated_weight_o,
  output logic [adw_pkg::IDX_W-1:0]         result_index_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [adw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [adw_pkg::DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned SLOT_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam longint unsigned SLOT_SH = 64'(adw_pkg::IDX_W + SLOT_W);
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << SLOT_SH) + 64'(NUM_ELEMENTS) - 64'd1) / 64'(NUM_ELEMENTS);

  logic en;
  logic accept;

  // Configuration.
  logic [adw_pkg::DATA_W-1:0]  lr_q;
  logic [adw_pkg::BATCH_W-1:0] batch_q;
  logic [adw_pkg::BATCH_W-1:0] batch_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= adw_pkg::LR_RESET;
      batch_q <= adw_pkg::BATCH_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == adw_pkg::REG_LEARNING_RATE) begin
        lr_q <= cfg_data_i;
      end else if (cfg_index_i == adw_pkg::REG_BATCH_SIZE) begin
        batch_q <= cfg_data_i[adw_pkg::BATCH_W-1:0];
      end
    end
  end

  assign batch_eff = (batch_q == '0) ? adw_pkg::BATCH_RESET : batch_q;

  // Clearing pass.
  logic              clearing_q;
  logic [SLOT_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      if (clr_cnt_q == SLOT_W'(NUM_ELEMENTS - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
      end
    end
  end

  // Output stage state is declared early for the stall.
  logic                       vo_q;
  logic [adw_pkg::DATA_W-1:0] nw_q;
  logic [adw_pkg::IDX_W-1:0]  ro_q;

  assign en         = !(vo_q && out_stall_i);
  assign in_stall_o = !en || clearing_q;
  assign accept     = in_valid_i && !in_stall_o;

  // Stage P: register the request and the slot quotient.
  logic                       vp_q;
  adw_pkg::item_t             item_p_q;
  logic [adw_pkg::IDX_W-1:0]  qdiv_p_q;
  logic                       neg_in;
  logic [adw_pkg::DATA_W-1:0] mag_in;
  logic [63:0]                qprod;

  assign neg_in = gradient_i[adw_pkg::DATA_W-1];
  assign mag_in = neg_in ? (32'd0 - adw_pkg::DATA_W'(gradient_i))
                         : adw_pkg::DATA_W'(gradient_i);
  assign qprod  = (64'(element_index_i) * RECIP_MUL) >> SLOT_SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_p_q.index  <= element_index_i;
      item_p_q.neg    <= neg_in;
      item_p_q.weight <= adw_pkg::DATA_W'(weight_i);
      item_p_q.mag    <= mag_in;
      qdiv_p_q        <= qprod[adw_pkg::IDX_W-1:0];
    end
  end

  logic [31:0]       slot_full;
  logic [SLOT_W-1:0] slot_p;

  assign slot_full = 32'(item_p_q.index) - 32'(qdiv_p_q) * 32'(NUM_ELEMENTS);
  assign slot_p    = slot_full[SLOT_W-1:0];

  // Stage A: memory read data, squared gradient, accumulate and write back.
  logic                      va_q;
  adw_pkg::item_t            item_a_q;
  logic [SLOT_W-1:0]         slot_a_q;
  logic [adw_pkg::ACC_W-1:0] sq_a_q;
  logic [adw_pkg::ACC_W-1:0] rdata_a_q;
  logic [adw_pkg::ACC_W-1:0] mem_q [NUM_ELEMENTS];

  logic                      wr_vld_q;
  logic [SLOT_W-1:0]         wr_slot_q;
  logic [adw_pkg::ACC_W-1:0] wr_val_q;

  logic [adw_pkg::ACC_W-1:0] acc_base;
  logic [adw_pkg::ACC_W:0]   acc_sum;
  logic [adw_pkg::ACC_W-1:0] acc_new;
  logic                      mem_we;
  logic [SLOT_W-1:0]         mem_wa;
  logic [adw_pkg::ACC_W-1:0] mem_wd;
  logic                      upd_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_a_q <= item_p_q;
      slot_a_q <= slot_p;
      sq_a_q   <= 64'(item_p_q.mag) * 64'(item_p_q.mag);
    end
  end

  assign acc_base = (wr_vld_q && wr_slot_q == slot_a_q) ? wr_val_q : rdata_a_q;
  assign acc_sum  = {1'b0, acc_base} + {1'b0, sq_a_q};
  assign acc_new  = acc_sum[adw_pkg::ACC_W] ? '1 : acc_sum[adw_pkg::ACC_W-1:0];

  assign upd_we = en && va_q;
  assign mem_we = clearing_q || upd_we;
  assign mem_wa = clearing_q ? clr_cnt_q : slot_a_q;
  assign mem_wd = clearing_q ? '0 : acc_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (en) begin
      rdata_a_q <= mem_q[slot_p];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_vld_q <= 1'b0;
    end else if (upd_we) begin
      wr_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      wr_slot_q <= slot_a_q;
      wr_val_q  <= acc_new;
    end
  end

  // Square root.
  logic                       vs;
  logic [adw_pkg::ROOT_W-1:0] root_s;
  adw_pkg::item_t             item_s;

  adw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va_q),
    .value_i (acc_new),
    .item_i  (item_a_q),
    .valid_o (vs),
    .root_o  (root_s),
    .item_o  (item_s)
  );

  // Stage M: numerator and divisor products.
  logic                      vm_q;
  adw_pkg::item_t            item_m_q;
  logic [adw_pkg::ACC_W-1:0] num_m_q;
  logic [adw_pkg::DEN_W-1:0] den_m_q;
  logic [48:0]               den_full;

  assign den_full = 49'(batch_eff) * 49'({1'b0, root_s} + 33'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_m_q <= item_s;
      num_m_q  <= 64'(lr_q) * 64'(item_s.mag);
      den_m_q  <= den_full[adw_pkg::DEN_W-1:0];
    end
  end

  // Divider.
  logic                       vd;
  logic [adw_pkg::QUOT_W-1:0] quot_d;
  logic                       sat_d;
  adw_pkg::item_t             item_d;

  adw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vm_q),
    .num_i   (num_m_q),
    .den_i   (den_m_q),
    .item_i  (item_m_q),
    .valid_o (vd),
    .quot_o  (quot_d),
    .sat_o   (sat_d),
    .item_o  (item_d)
  );

  // Stage O: apply the step and saturate.
  logic [adw_pkg::QUOT_W-1:0] step;
  logic signed [35:0]         wv;
  logic signed [35:0]         nw;
  logic [adw_pkg::DATA_W-1:0] nw_d;

  always_comb begin
    step = (sat_d || quot_d > adw_pkg::STEP_MAX) ? adw_pkg::STEP_MAX : quot_d;
    wv   = 36'(signed'(item_d.weight));
    if (item_d.neg) begin
      nw = wv + signed'({2'b00, step});
    end else begin
      nw = wv - signed'({2'b00, step});
    end
    if (nw > 36'sh0_7FFF_FFFF) begin
      nw_d = 32'h7FFF_FFFF;
    end else if (nw < -36'sh0_8000_0000) begin
      nw_d = 32'h8000_0000;
    end else begin
      nw_d = nw[adw_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nw_q <= nw_d;
      ro_q <= item_d.index;
    end
  end

  assign out_valid_o      = vo_q;
  assign updated_weight_o = signed'(nw_q);
  assign result_index_o   = ro_q;

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !vp_q && !va_q)
    else $error("request in flight during accumulator clearing");

  a_wr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_we |=> wr_vld_q && wr_slot_q == $past(slot_a_q) && wr_val_q == $past(acc_new))
    else $error("last-write record does not follow the accumulator update");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> out_valid_o)
    else $error("pipeline stalled without a pending result");

endmodule

>>> rtl/core/adw_sqrt.sv
// ----------------------------------------------------------------------------
// adw_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module adw_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [adw_pkg::ACC_W-1:0]     value_i,
  input  adw_pkg::item_t                item_i,
  output logic                          valid_o,
  output logic [adw_pkg::ROOT_W-1:0]    root_o,
  output adw_pkg::item_t                item_o
);

  localparam int unsigned NS = adw_pkg::SQRT_STAGES;

  logic                          vld_q  [NS];
  logic [adw_pkg::ACC_W-1:0]     val_q  [NS];
  logic [34:0]                   rem_q  [NS];
  logic [adw_pkg::ROOT_W-1:0]    root_q [NS];
  adw_pkg::item_t                item_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                       vld_in;
    logic [adw_pkg::ACC_W-1:0]  val_in;
    logic [34:0]                rem_in;
    logic [adw_pkg::ROOT_W-1:0] root_in;
    adw_pkg::item_t             item_in;
    logic [34:0]                rem_sh;
    logic [34:0]                trial;
    logic [34:0]                rem_d;
    logic [adw_pkg::ROOT_W-1:0] root_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign val_in  = value_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign item_in = item_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign val_in  = val_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign item_in = item_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[32:0], val_in[63:62]};
      trial  = {1'b0, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[k]  <= {val_in[61:0], 2'b00};
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        item_q[k] <= item_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign item_o  = item_q[NS-1];

endmodule

>>> rtl/core/adw_div.sv
// ----------------------------------------------------------------------------
// adw_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module adw_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [adw_pkg::ACC_W-1:0]     num_i,
  input  logic [adw_pkg::DEN_W-1:0]     den_i,
  input  adw_pkg::item_t                item_i,
  output logic                          valid_o,
  output logic [adw_pkg::QUOT_W-1:0]    quot_o,
  output logic                          sat_o,
  output adw_pkg::item_t                item_o
);

  localparam int unsigned NS = adw_pkg::DIV_STAGES;
  localparam int unsigned WW = adw_pkg::DEN_W + adw_pkg::QUOT_W;

  logic                          vld_q  [NS];
  logic [adw_pkg::ACC_W-1:0]     rem_q  [NS];
  logic [adw_pkg::DEN_W-1:0]     den_q  [NS];
  logic [adw_pkg::QUOT_W-1:0]    quot_q [NS];
  logic                          sat_q  [NS];
  adw_pkg::item_t                item_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                        vld_in;
    logic [adw_pkg::ACC_W-1:0]   rem_in;
    logic [adw_pkg::DEN_W-1:0]   den_in;
    logic [adw_pkg::QUOT_W-1:0]  quot_in;
    logic                        sat_in;
    adw_pkg::item_t              item_in;
    logic [WW-1:0]               den_sh;
    logic                        fits;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
      assign sat_in  = {{(WW-adw_pkg::ACC_W){1'b0}}, num_i} >=
                       {den_i, {adw_pkg::QUOT_W{1'b0}}};
      assign item_in = item_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign sat_in  = sat_q[k-1];
      assign item_in = item_q[k-1];
    end

    always_comb begin
      den_sh = {{adw_pkg::QUOT_W{1'b0}}, den_in} << (NS - 1 - k);
      fits   = {{(WW-adw_pkg::ACC_W){1'b0}}, rem_in} >= den_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fits ? (rem_in - den_sh[adw_pkg::ACC_W-1:0]) : rem_in;
        den_q[k]  <= den_in;
        quot_q[k] <= {quot_in[adw_pkg::QUOT_W-2:0], fits};
        sat_q[k]  <= sat_in;
        item_q[k] <= item_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quot_o  = quot_q[NS-1];
  assign sat_o   = sat_q[NS-1];
  assign item_o  = item_q[NS-1];

endmodule
